FILE: hdl/mrsr_pkg.sv
package mrsr_pkg;

    localparam int ID_MEMBERS = 8;
    localparam int ENABLE_W   = 8;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    localparam logic REG_MEMBER_ENABLE = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_SHIFT,
        S_RESULT
    } t_state;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TOO_LONG   = 3'd1,
        ST_NOT_MEMBER = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_NOT_FOUND  = 3'd4,
        ST_ABANDONED  = 3'd5
    } t_status;

    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

FILE: hdl/mailbox_ring_selective_receive.sv
// Per-member mailbox rings with selective receive.
// Input channel (i_valid, o_stall): one transfer carries a send or a receive
// request. Output channel (o_valid, i_stall): one transfer per request with
// status, returned length and data word. The APB port holds the member
// enable register; enabling a member empties its ring.
// All messages live in one slot memory with a single read port and a single
// write port, addressed by member and ring position.
// A send raises o_valid after decode with the slot write, then the result
// register. A receive-any passes decode, slot read, match and result. A
// receive-from reads one slot a cycle from newest to oldest, then moves each
// newer entry down one slot a cycle; the single read port of the slot memory
// sets this pace. The input accepts the next request in the same cycle that
// o_valid rises.
// The input is stalled while a request is being worked on. A finished result
// waits in the output register while the receiver stalls, and the next
// request is taken in the meantime; it finishes only once that register is
// free. Reset clears the enable register, every count and each ring's newest
// pointer; slot contents are undefined until written and need no clear pass.
module mailbox_ring_selective_receive #(
    parameter int MEMBERS    = 8,
    parameter int POOL_DEPTH = 16,
    parameter int DATA_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [2:0]  i_source_id,
    input  logic [2:0]  i_dest_id,
    input  logic        i_any_sender,
    input  logic [7:0]  i_length,
    input  logic [63:0] i_payload,
    input  logic [7:0]  i_info_size,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_returned_length,
    output logic [63:0] o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NM    = (MEMBERS < mrsr_pkg::ID_MEMBERS) ? MEMBERS : mrsr_pkg::ID_MEMBERS;
    localparam int NMW   = $clog2(NM);
    localparam int PW    = $clog2(POOL_DEPTH);
    localparam int CW    = $clog2(POOL_DEPTH + 1);
    localparam int DEPTH = NM * POOL_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = 8 * DATA_BYTES;
    localparam int EW    = DW + 11;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PW'(POOL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
        return (p == '0) ? PW'(POOL_DEPTH - 1) : p - 1'b1;
    endfunction

    mrsr_pkg::t_state r_state, n_state;

    logic [mrsr_pkg::ENABLE_W-1:0] r_enable;
    logic [CW-1:0] r_count  [NM];
    logic [PW-1:0] r_newest [NM];

    logic [EW-1:0] r_slot_mem [DEPTH];
    logic [EW-1:0] r_rd_data;

    logic          r_op;
    logic [2:0]    r_src;
    logic [2:0]    r_dst;
    logic          r_any;
    logic [7:0]    r_len;
    logic [DW-1:0] r_payload;
    logic [7:0]    r_info;

    logic [PW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_left, n_left;
    logic          r_pend, n_pend;
    logic [PW-1:0] r_pend_ptr, n_pend_ptr;
    logic [PW-1:0] r_q, n_q;
    logic          r_more, n_more;
    logic [PW-1:0] r_cur_new, n_cur_new;
    logic [DW-1:0] r_take_data, n_take_data;
    logic [7:0]    r_take_info, n_take_info;
    logic [2:0]    r_res_status, n_res_status;
    logic [7:0]    r_res_rlen, n_res_rlen;
    logic [DW-1:0] r_res_data, n_res_data;

    logic          r_o_valid;
    logic [2:0]    r_o_status;
    logic [7:0]    r_o_rlen;
    logic [63:0]   r_o_data;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata;

    logic [NMW-1:0] idx;
    logic [AW-1:0]  base;
    logic           is_mem;
    logic [CW-1:0]  cur_cnt;
    logic [PW-1:0]  cur_new;
    logic [PW-1:0]  send_ptr;
    logic [2:0]     rd_sender;
    logic [7:0]     rd_info;
    logic [DW-1:0]  rd_word;
    logic           send_ok, recv_go, match, match_in_place, shift_last, recv_fin;
    logic           out_free, cfg_we;
    logic [mrsr_pkg::ENABLE_W-1:0] rising;
    logic [DW-1:0]  fin_data;
    logic [7:0]     fin_info;
    logic [7:0]     eff;
    logic [63:0]    send_mask, recv_mask;

    assign idx      = r_dst[NMW-1:0];
    assign base     = AW'(idx) * AW'(POOL_DEPTH);
    assign is_mem   = (32'(r_dst) < MEMBERS) && r_enable[r_dst];
    assign cur_cnt  = r_count[idx];
    assign cur_new  = r_newest[idx];
    assign send_ptr = ring_next(cur_new);

    assign rd_sender = r_rd_data[EW-1 -: 3];
    assign rd_info   = r_rd_data[DW +: 8];
    assign rd_word   = r_rd_data[DW-1:0];

    assign send_ok = (r_op == mrsr_pkg::OP_SEND) && (r_len <= 8'(DATA_BYTES)) && is_mem;
    assign recv_go = (r_op == mrsr_pkg::OP_RECV) && is_mem && (cur_cnt != '0);
    assign match   = r_pend && (r_any || (rd_sender == r_src));
    assign match_in_place = match && (r_pend_ptr == r_cur_new);
    assign shift_last = r_pend && !r_more;
    assign recv_fin = ((r_state == mrsr_pkg::S_SEARCH) && match_in_place) ||
                      ((r_state == mrsr_pkg::S_SHIFT) && shift_last);
    assign out_free = !r_o_valid || !i_stall;

    assign fin_data  = (r_state == mrsr_pkg::S_SEARCH) ? rd_word : r_take_data;
    assign fin_info  = (r_state == mrsr_pkg::S_SEARCH) ? rd_info : r_take_info;
    assign eff       = (r_len > 8'(DATA_BYTES)) ? 8'(DATA_BYTES) : r_len;
    assign send_mask = mrsr_pkg::byte_mask(r_len[3:0]);
    assign recv_mask = mrsr_pkg::byte_mask(eff[3:0]);

    assign cfg_we = psel && penable && pwrite && (paddr[2] == mrsr_pkg::REG_MEMBER_ENABLE);
    assign rising = pwdata[mrsr_pkg::ENABLE_W-1:0] & ~r_enable;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == mrsr_pkg::REG_MEMBER_ENABLE) ? 32'(r_enable) : '0;

    assign o_stall           = (r_state != mrsr_pkg::S_IDLE);
    assign o_valid           = r_o_valid;
    assign o_status          = r_o_status;
    assign o_returned_length = r_o_rlen;
    assign o_data            = r_o_data;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mrsr_pkg::S_IDLE: begin
                if (i_valid) n_state = mrsr_pkg::S_DECODE;
            end
            mrsr_pkg::S_DECODE: begin
                n_state = recv_go ? mrsr_pkg::S_SEARCH : mrsr_pkg::S_RESULT;
            end
            mrsr_pkg::S_SEARCH: begin
                priority if (match && !match_in_place) begin
                    n_state = mrsr_pkg::S_SHIFT;
                end else if (match || (r_left == '0)) begin
                    n_state = mrsr_pkg::S_RESULT;
                end else begin
                    n_state = mrsr_pkg::S_SEARCH;
                end
            end
            mrsr_pkg::S_SHIFT: begin
                if (shift_last) n_state = mrsr_pkg::S_RESULT;
            end
            mrsr_pkg::S_RESULT: begin
                if (out_free) n_state = mrsr_pkg::S_IDLE;
            end
            default: n_state = mrsr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_ptr        = r_ptr;
        n_left       = r_left;
        n_pend       = r_pend;
        n_pend_ptr   = r_pend_ptr;
        n_q          = r_q;
        n_more       = r_more;
        n_cur_new    = r_cur_new;
        n_take_data  = r_take_data;
        n_take_info  = r_take_info;
        n_res_status = r_res_status;
        n_res_rlen   = r_res_rlen;
        n_res_data   = r_res_data;
        mem_we       = 1'b0;
        mem_waddr    = base + AW'(send_ptr);
        mem_wdata    = {r_src, r_info, r_payload & send_mask[DW-1:0]};
        mem_re       = 1'b0;
        mem_raddr    = base + AW'(r_ptr);
        unique case (r_state)
            mrsr_pkg::S_DECODE: begin
                n_res_rlen = '0;
                n_res_data = '0;
                if (r_op == mrsr_pkg::OP_SEND) begin
                    priority if (r_len > 8'(DATA_BYTES)) begin
                        n_res_status = mrsr_pkg::ST_TOO_LONG;
                    end else if (!is_mem) begin
                        n_res_status = mrsr_pkg::ST_NOT_MEMBER;
                    end else begin
                        mem_we       = 1'b1;
                        n_res_status = mrsr_pkg::ST_OK;
                        n_res_rlen   = r_len;
                    end
                end else begin
                    priority if (!is_mem) begin
                        n_res_status = mrsr_pkg::ST_NOT_MEMBER;
                    end else if (cur_cnt == '0) begin
                        n_res_status = mrsr_pkg::ST_EMPTY;
                    end else begin
                        n_ptr     = cur_new;
                        n_cur_new = cur_new;
                        n_left    = r_any ? CW'(1) : cur_cnt;
                        n_pend    = 1'b0;
                    end
                end
            end
            mrsr_pkg::S_SEARCH: begin
                if (r_left != '0) begin
                    mem_re     = 1'b1;
                    n_ptr      = ring_prev(r_ptr);
                    n_left     = r_left - 1'b1;
                    n_pend     = 1'b1;
                    n_pend_ptr = r_ptr;
                end else begin
                    n_pend = 1'b0;
                end
                if (match) begin
                    n_take_data = rd_word;
                    n_take_info = rd_info;
                    n_q         = r_pend_ptr;
                    n_ptr       = ring_next(r_pend_ptr);
                    n_more      = 1'b1;
                    n_pend      = 1'b0;
                end else if (r_left == '0) begin
                    n_res_status = mrsr_pkg::ST_NOT_FOUND;
                    n_res_rlen   = '0;
                    n_res_data   = '0;
                end
            end
            mrsr_pkg::S_SHIFT: begin
                if (r_more) begin
                    mem_re = 1'b1;
                    n_ptr  = ring_next(r_ptr);
                    n_pend = 1'b1;
                    if (r_ptr == r_cur_new) n_more = 1'b0;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = base + AW'(r_q);
                    mem_wdata = r_rd_data;
                    n_q       = ring_next(r_q);
                end
            end
            default: begin
            end
        endcase
        if (recv_fin) begin
            if (fin_info > r_len) begin
                n_res_status = mrsr_pkg::ST_ABANDONED;
                n_res_rlen   = '0;
                n_res_data   = '0;
            end else begin
                n_res_status = mrsr_pkg::ST_OK;
                n_res_rlen   = eff;
                n_res_data   = fin_data & recv_mask[DW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_slot_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mrsr_pkg::S_IDLE;
            r_enable  <= '0;
            r_o_valid <= 1'b0;
            r_pend    <= 1'b0;
            r_more    <= 1'b0;
            r_left    <= '0;
            for (int m = 0; m < NM; m++) begin
                r_count[m]  <= '0;
                r_newest[m] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_more  <= n_more;
            r_left  <= n_left;
            if (cfg_we) begin
                r_enable <= pwdata[mrsr_pkg::ENABLE_W-1:0];
                for (int m = 0; m < NM; m++) begin
                    if (rising[m]) begin
                        r_count[m]  <= '0;
                        r_newest[m] <= '0;
                    end
                end
            end
            if ((r_state == mrsr_pkg::S_DECODE) && send_ok) begin
                r_newest[idx] <= send_ptr;
                if (cur_cnt < CW'(POOL_DEPTH)) r_count[idx] <= cur_cnt + 1'b1;
            end
            if (recv_fin) begin
                r_newest[idx] <= ring_prev(r_cur_new);
                r_count[idx]  <= cur_cnt - 1'b1;
            end
            if ((r_state == mrsr_pkg::S_RESULT) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == mrsr_pkg::S_IDLE) && i_valid) begin
            r_op      <= i_operation;
            r_src     <= i_source_id;
            r_dst     <= i_dest_id;
            r_any     <= i_any_sender;
            r_len     <= i_length;
            r_payload <= i_payload[DW-1:0];
            r_info    <= i_info_size;
        end
        r_ptr        <= n_ptr;
        r_pend_ptr   <= n_pend_ptr;
        r_q          <= n_q;
        r_cur_new    <= n_cur_new;
        r_take_data  <= n_take_data;
        r_take_info  <= n_take_info;
        r_res_status <= n_res_status;
        r_res_rlen   <= n_res_rlen;
        r_res_data   <= n_res_data;
        if ((r_state == mrsr_pkg::S_RESULT) && out_free) begin
            r_o_status <= r_res_status;
            r_o_rlen   <= r_res_rlen;
            r_o_data   <= 64'(r_res_data);
        end
    end

    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("slot memory read and written at the same entry");

    a_stall_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after a transfer");

    a_rlen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_returned_length <= 8'(DATA_BYTES)))
        else $error("returned length above the slot size");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mrsr_pkg::S_SEARCH) |-> (r_left <= CW'(POOL_DEPTH)))
        else $error("search runs beyond the ring");

endmodule

FILE: dv/tb_mailbox_ring_selective_receive.sv
module tb_mailbox_ring_selective_receive;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING = 16;
    localparam int WORD_BYTES = 8;

    typedef struct packed {
        logic        op;
        logic [2:0]  src;
        logic [2:0]  dst;
        logic        any;
        logic [7:0]  len;
        logic [63:0] payload;
        logic [7:0]  info;
    } t_mbox_req;

    typedef struct packed {
        mrsr_pkg::t_status status;
        logic [7:0]        rlen;
        logic [63:0]       data;
    } t_mbox_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_operation = mrsr_pkg::OP_SEND;
    logic [2:0]  i_source_id = '0;
    logic [2:0]  i_dest_id = '0;
    logic        i_any_sender = 1'b0;
    logic [7:0]  i_length = '0;
    logic [63:0] i_payload = '0;
    logic [7:0]  i_info_size = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [7:0]  o_returned_length;
    logic [63:0] o_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mailbox_ring_selective_receive dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_operation       (i_operation),
        .i_source_id       (i_source_id),
        .i_dest_id         (i_dest_id),
        .i_any_sender      (i_any_sender),
        .i_length          (i_length),
        .i_payload         (i_payload),
        .i_info_size       (i_info_size),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_returned_length (o_returned_length),
        .o_data            (o_data),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    logic [63:0]  slot_word [mrsr_pkg::ID_MEMBERS][RING];
    logic [2:0]   slot_from [mrsr_pkg::ID_MEMBERS][RING];
    logic [7:0]   slot_hdr  [mrsr_pkg::ID_MEMBERS][RING];
    int unsigned  held      [mrsr_pkg::ID_MEMBERS];
    logic [3:0]   head      [mrsr_pkg::ID_MEMBERS];
    logic [7:0]   enabled = '0;

    t_mbox_result pending_results [$];
    int unsigned  errors = 0;
    bit           gaps_on = 1'b1;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL mailbox_ring_selective_receive");
        $finish;
    end

    function automatic logic [63:0] keep_bytes(input logic [63:0] w, input int unsigned n);
        if (n >= WORD_BYTES) return w;
        return w & ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic predict_mailbox(input t_mbox_req r);
        t_mbox_result res;
        logic [3:0]   p;
        logic [3:0]   q;
        logic [3:0]   n;
        logic [3:0]   top;
        logic [63:0]  word;
        logic [7:0]   hdr;
        int unsigned  k;
        int unsigned  eff;
        bit           found;
        res.status = mrsr_pkg::ST_OK;
        res.rlen = '0;
        res.data = '0;
        if (r.op == mrsr_pkg::OP_SEND) begin
            if (r.len > WORD_BYTES) begin
                res.status = mrsr_pkg::ST_TOO_LONG;
            end else if (!enabled[r.dst]) begin
                res.status = mrsr_pkg::ST_NOT_MEMBER;
            end else begin
                p = head[r.dst] + 4'd1;
                head[r.dst] = p;
                slot_word[r.dst][p] = keep_bytes(r.payload, r.len);
                slot_from[r.dst][p] = r.src;
                slot_hdr[r.dst][p] = r.info;
                if (held[r.dst] < RING) held[r.dst]++;
                res.rlen = r.len;
            end
        end else if (!enabled[r.dst]) begin
            res.status = mrsr_pkg::ST_NOT_MEMBER;
        end else if (held[r.dst] == 0) begin
            res.status = mrsr_pkg::ST_EMPTY;
        end else begin
            top = head[r.dst];
            p = top;
            found = r.any;
            for (k = 0; k < held[r.dst] && !found; k++) begin
                if (slot_from[r.dst][p] == r.src) begin
                    found = 1'b1;
                end else begin
                    p = p - 4'd1;
                end
            end
            if (!found) begin
                res.status = mrsr_pkg::ST_NOT_FOUND;
            end else begin
                word = slot_word[r.dst][p];
                hdr = slot_hdr[r.dst][p];
                for (q = p; q != top; q = n) begin
                    n = q + 4'd1;
                    slot_word[r.dst][q] = slot_word[r.dst][n];
                    slot_from[r.dst][q] = slot_from[r.dst][n];
                    slot_hdr[r.dst][q] = slot_hdr[r.dst][n];
                end
                head[r.dst] = top - 4'd1;
                held[r.dst]--;
                if (hdr > r.len) begin
                    res.status = mrsr_pkg::ST_ABANDONED;
                end else begin
                    eff = (r.len > WORD_BYTES) ? WORD_BYTES : r.len;
                    res.data = keep_bytes(word, eff);
                    res.rlen = 8'(eff);
                end
            end
        end
        pending_results.push_back(res);
    endtask

    task automatic send_request(input t_mbox_req r);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= r.op;
        i_source_id  <= r.src;
        i_dest_id    <= r.dst;
        i_any_sender <= r.any;
        i_length     <= r.len;
        i_payload    <= r.payload;
        i_info_size  <= r.info;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_mailbox(r);
    endtask

    task automatic send_msg(input logic [2:0] dst, input logic [2:0] src, input logic [7:0] len,
                            input logic [63:0] payload, input logic [7:0] info);
        t_mbox_req r;
        r.op = mrsr_pkg::OP_SEND;
        r.src = src;
        r.dst = dst;
        r.any = $urandom_range(0, 1);
        r.len = len;
        r.payload = payload;
        r.info = info;
        send_request(r);
    endtask

    task automatic recv_msg(input logic [2:0] dst, input logic [2:0] src, input logic any,
                            input logic [7:0] len);
        t_mbox_req r;
        r.op = mrsr_pkg::OP_RECV;
        r.src = src;
        r.dst = dst;
        r.any = any;
        r.len = len;
        r.payload = {$urandom, $urandom};
        r.info = 8'($urandom);
        send_request(r);
    endtask

    task automatic write_enable(input logic [7:0] value);
        logic [7:0] rising;
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {mrsr_pkg::REG_MEMBER_ENABLE, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {24'd0, value}) begin
            $display("%0t: enable register expected %h actual %h", $time, value, prdata);
            errors++;
        end
        if (pready !== 1'b1) begin
            $display("%0t: pready expected 1 actual %b", $time, pready);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        rising = value & ~enabled;
        for (int m = 0; m < mrsr_pkg::ID_MEMBERS; m++) begin
            if (rising[m]) begin
                held[m] = 0;
                head[m] = '0;
            end
        end
        enabled = value;
    endtask

    task automatic test_refusals();
        send_msg(3'd3, 3'd1, 8'd4, 64'h0123_4567_89AB_CDEF, 8'd0);
        send_msg(3'd0, 3'd1, 8'd9, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
        recv_msg(3'd5, 3'd0, 1'b1, 8'd8);
    endtask

    task automatic test_send_fields();
        write_enable(8'hFF);
        send_msg(3'd0, 3'd7, 8'd8, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
        send_msg(3'd0, 3'd0, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255);
        send_msg(3'd7, 3'd3, 8'd1, {$urandom, $urandom}, 8'd8);
        send_msg(3'd7, 3'd3, 8'd255, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
    endtask

    task automatic test_receive_paths();
        recv_msg(3'd1, 3'd0, 1'b1, 8'd8);
        recv_msg(3'd0, 3'd5, 1'b0, 8'd8);
        send_msg(3'd0, 3'd2, 8'd3, 64'hA5A5_A5A5_A5A5_A5A5, 8'd2);
        recv_msg(3'd0, 3'd7, 1'b0, 8'd8);
        recv_msg(3'd0, 3'd4, 1'b1, 8'd255);
        recv_msg(3'd0, 3'd0, 1'b1, 8'd0);
        recv_msg(3'd0, 3'd0, 1'b1, 8'd8);
        recv_msg(3'd7, 3'd3, 1'b0, 8'd0);
        send_msg(3'd7, 3'd4, 8'd5, {$urandom, $urandom}, 8'd0);
        recv_msg(3'd7, 3'd4, 1'b0, 8'd0);
    endtask

    task automatic test_disable_keeps_state();
        send_msg(3'd7, 3'd6, 8'd8, {$urandom, $urandom}, 8'd1);
        write_enable(8'h7F);
        send_msg(3'd7, 3'd6, 8'd8, {$urandom, $urandom}, 8'd1);
        recv_msg(3'd7, 3'd6, 1'b1, 8'd8);
        write_enable(8'hFF);
        recv_msg(3'd7, 3'd6, 1'b1, 8'd8);
    endtask

    task automatic test_random_traffic(input logic [7:0] enable_value, input int unsigned items,
                                       input logic [2:0] hot);
        t_mbox_req r;
        write_enable(enable_value);
        repeat (items) begin
            r.op = ($urandom_range(0, 99) < 55) ? mrsr_pkg::OP_SEND : mrsr_pkg::OP_RECV;
            r.dst = ($urandom_range(0, 99) < 70) ? hot : 3'($urandom_range(0, 7));
            r.src = ($urandom_range(0, 99) < 60) ? 3'($urandom_range(0, 2))
                                                 : 3'($urandom_range(0, 7));
            r.any = ($urandom_range(0, 99) < 35);
            r.len = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 8))
                                                 : 8'($urandom_range(9, 255));
            r.payload = {$urandom, $urandom};
            r.info = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 8)) : 8'($urandom);
            send_request(r);
        end
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        test_random_traffic(8'hFF, 300, 3'd5);
        gaps_on = 1'b1;
    endtask

    initial begin : receiver_stall
        int unsigned hold;
        int unsigned r;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (!gaps_on) begin
                i_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    i_stall <= 1'b0;
                    hold = $urandom_range(0, 6);
                end else if (r < 92) begin
                    i_stall <= 1'b1;
                    hold = $urandom_range(0, 3);
                end else begin
                    i_stall <= 1'b1;
                    hold = $urandom_range(10, 40);
                end
            end
        end
    end

    initial begin : result_check
        t_mbox_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result transfer with none expected: status %0d length %0d",
                             $time, o_status, o_returned_length);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_status);
                        errors++;
                    end
                    if (o_returned_length !== want.rlen) begin
                        $display("%0t: returned length expected %0d actual %0d",
                                 $time, want.rlen, o_returned_length);
                        errors++;
                    end
                    if (o_data !== want.data) begin
                        $display("%0t: data expected %h actual %h", $time, want.data, o_data);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        for (int m = 0; m < mrsr_pkg::ID_MEMBERS; m++) begin
            held[m] = 0;
            head[m] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_refusals();
        test_send_fields();
        test_receive_paths();
        test_disable_keeps_state();
        test_random_traffic(8'hFF, 570, 3'd0);
        test_random_traffic(8'h0F, 300, 3'd1);
        test_random_traffic(8'h00, 60, 3'd4);
        test_random_traffic(8'h80, 250, 3'd7);
        test_random_traffic(8'($urandom), 300, 3'($urandom_range(0, 7)));
        test_back_to_back();

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS mailbox_ring_selective_receive");
        end else begin
            $display("FAIL mailbox_ring_selective_receive");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/mrsr_pkg.sv
hdl/mailbox_ring_selective_receive.sv
dv/tb_mailbox_ring_selective_receive.sv
